// File: sv/lcps_pkg.sv
package lcps_pkg;

  // Pin layout
  localparam int PINS_PER_GROUP = 8;
  localparam int PIN_W          = (PINS_PER_GROUP > 1) ? $clog2(PINS_PER_GROUP) : 1;
  localparam int LEVEL_W        = 16;
  localparam int MAX_GROUPS     = 2;
  localparam int GRP_W          = 2;   // walk position can reach MAX_GROUPS

  // Field widths
  localparam int SEQ_W  = 2;
  localparam int SUB_W  = 2;
  localparam int HOLD_W = 7;
  localparam int CNT_W  = 2;

  // Hold schedule (ms)
  localparam int BLINK_FIRST_HOLD = 100;
  localparam int SNAKE_FIRST_HOLD = 20;
  localparam int MIN_HOLD         = 8;
  localparam int HOLD_STEP        = 4;
  localparam int SUB_HOLD         = 4;
  localparam int SUB_COUNT        = 3;

  localparam logic [LEVEL_W-1:0] ALL_PINS_MASK =
    (2 * PINS_PER_GROUP >= LEVEL_W) ? {LEVEL_W{1'b1}} :
    LEVEL_W'((1 << (2 * PINS_PER_GROUP)) - 1);

  // Sequence codes
  localparam logic [SEQ_W-1:0] SEQ_BLINK = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_FWD   = 2'd1;
  localparam logic [SEQ_W-1:0] SEQ_REV   = 2'd2;
  localparam logic [SEQ_W-1:0] SEQ_MIX   = 2'd3;

  // Sub-pattern codes inside the mixed sequence
  localparam logic [SUB_W-1:0] SUB_FWD   = 2'd0;
  localparam logic [SUB_W-1:0] SUB_BLINK = 2'd1;
  localparam logic [SUB_W-1:0] SUB_REV   = 2'd2;

  typedef enum logic [1:0] {
    KIND_BLINK,
    KIND_FWD,
    KIND_REV
  } kind_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [HOLD_W-1:0] hold;
    logic [SUB_W-1:0]  sub;
    logic              phase;   // 0: writing LOW, 1: writing HIGH
    logic [GRP_W-1:0]  grp;
    logic [PIN_W-1:0]  pin;
  } walk_t;

endpackage

// File: sv/lcps_engine.sv
module lcps_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [lcps_pkg::CNT_W-1:0]   expander_count,
  output logic [lcps_pkg::LEVEL_W-1:0] pin_levels_nxt,
  output logic [lcps_pkg::SEQ_W-1:0]   sequence_nxt
);
  import lcps_pkg::*;

  function automatic logic [HOLD_W-1:0] first_hold(input logic [SEQ_W-1:0] s);
    return (s == SEQ_FWD || s == SEQ_REV) ? HOLD_W'(SNAKE_FIRST_HOLD)
                                          : HOLD_W'(BLINK_FIRST_HOLD);
  endfunction

  function automatic kind_t unit_kind(input walk_t w);
    kind_t k;
    case (w.seq)
      SEQ_BLINK: k = KIND_BLINK;
      SEQ_FWD:   k = KIND_FWD;
      SEQ_REV:   k = KIND_REV;
      default: begin
        case (w.sub)
          SUB_FWD:   k = KIND_FWD;
          SUB_BLINK: k = KIND_BLINK;
          default:   k = KIND_REV;
        endcase
      end
    endcase
    return k;
  endfunction

  function automatic logic [HOLD_W-1:0] unit_hold(input walk_t w);
    return (w.seq == SEQ_MIX && w.sub != SUB_BLINK) ? HOLD_W'(SUB_HOLD) : w.hold;
  endfunction

  // End of one blink/snake unit: next sub-pattern, next hold or next sequence
  function automatic walk_t unit_done(input walk_t w);
    walk_t             r;
    logic [HOLD_W-1:0] h;
    r       = w;
    r.phase = 1'b0;
    r.grp   = '0;
    r.pin   = '0;
    h       = w.hold - HOLD_W'(HOLD_STEP);
    if (w.seq == SEQ_MIX && w.sub != SUB_W'(SUB_COUNT - 1)) begin
      r.sub = w.sub + SUB_W'(1);
    end else begin
      r.sub = '0;
      if (h < HOLD_W'(MIN_HOLD)) begin
        r.seq  = w.seq + SEQ_W'(1);
        r.hold = first_hold(r.seq);
      end else begin
        r.hold = h;
      end
    end
    return r;
  endfunction

  walk_t              st_r, st_nxt;
  logic [HOLD_W-1:0]  wait_r, wait_nxt;
  logic [LEVEL_W-1:0] levels_r, levels_nxt;
  logic [SEQ_W-1:0]   playing_r, playing_nxt;

  // Write path signals
  logic [GRP_W-1:0]   fwd_groups;
  logic [GRP_W-1:0]   cur_groups;
  walk_t              wr, skip, after_wr;
  kind_t              wr_kind;
  logic [HOLD_W-1:0]  wr_hold;
  logic               gsel;
  logic [PIN_W-1:0]   psel;
  logic [LEVEL_W-1:0] pin_mask, wr_levels;
  int                 pos;

  assign fwd_groups = (expander_count > CNT_W'(MAX_GROUPS)) ? GRP_W'(MAX_GROUPS)
                                                            : GRP_W'(expander_count);

  // Resolve the walk position that actually writes: finished phases and
  // empty forward snakes fall through to the next write in the same tick.
  always_comb begin
    cur_groups = (unit_kind(st_r) == KIND_FWD) ? fwd_groups : GRP_W'(MAX_GROUPS);
    skip       = unit_done(st_r);
    wr         = st_r;
    if (unit_kind(st_r) != KIND_BLINK && st_r.grp >= cur_groups) begin
      if (!st_r.phase && cur_groups != '0) begin
        wr.phase = 1'b1;
        wr.grp   = '0;
        wr.pin   = '0;
      end else begin
        if (unit_kind(skip) == KIND_FWD && fwd_groups == '0) begin
          if (skip.seq == SEQ_MIX) begin
            skip.sub = SUB_BLINK;
          end else begin
            // rest of the forward-snake sequence is empty
            skip.seq  = SEQ_REV;
            skip.hold = first_hold(SEQ_REV);
            skip.sub  = SUB_FWD;
          end
        end
        wr = skip;
      end
    end
  end

  always_comb begin
    wr_kind   = unit_kind(wr);
    wr_hold   = unit_hold(wr);
    gsel      = (wr_kind == KIND_FWD) ? wr.grp[0] : ~wr.grp[0];
    psel      = (wr_kind == KIND_FWD) ? wr.pin : PIN_W'(PINS_PER_GROUP - 1) - wr.pin;
    pos       = int'(gsel) * PINS_PER_GROUP + int'(psel);
    pin_mask  = (pos < LEVEL_W) ? (LEVEL_W'(1) << pos) : '0;
    after_wr  = wr;
    if (wr_kind == KIND_BLINK) begin
      wr_levels = wr.phase ? (levels_r | ALL_PINS_MASK) : (levels_r & ~ALL_PINS_MASK);
      if (!wr.phase) begin
        after_wr.phase = 1'b1;
      end else begin
        after_wr = unit_done(wr);
      end
    end else begin
      wr_levels = wr.phase ? (levels_r | pin_mask) : (levels_r & ~pin_mask);
      if (wr.pin == PIN_W'(PINS_PER_GROUP - 1)) begin
        after_wr.pin = '0;
        after_wr.grp = wr.grp + GRP_W'(1);
      end else begin
        after_wr.pin = wr.pin + PIN_W'(1);
      end
    end
  end

  always_comb begin
    st_nxt      = st_r;
    wait_nxt    = wait_r;
    levels_nxt  = levels_r;
    playing_nxt = playing_r;
    if (step) begin
      if (wait_r == '0) begin
        st_nxt      = after_wr;
        wait_nxt    = wr_hold - HOLD_W'(1);
        levels_nxt  = wr_levels;
        playing_nxt = wr.seq;
      end else begin
        wait_nxt = wait_r - HOLD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{seq: SEQ_BLINK, hold: HOLD_W'(BLINK_FIRST_HOLD), sub: SUB_FWD,
                     phase: 1'b0, grp: '0, pin: '0};
      wait_r    <= '0;
      levels_r  <= '1;
      playing_r <= SEQ_BLINK;
    end else begin
      st_r      <= st_nxt;
      wait_r    <= wait_nxt;
      levels_r  <= levels_nxt;
      playing_r <= playing_nxt;
    end
  end

  assign pin_levels_nxt = levels_nxt;
  assign sequence_nxt   = playing_nxt;

  // Idle cycles freeze the pattern
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(levels_r) && $stable(wait_r) && $stable(st_r))
    else $error("pattern state moved without a tick");

  // Mid-hold ticks only count down
  a_hold_counts: assert property (@(posedge clk) disable iff (!rst_n)
    step && wait_r != '0 |=> wait_r == $past(wait_r) - HOLD_W'(1) && $stable(levels_r))
    else $error("hold countdown broken");

  // A write always loads a hold of the form 4k-1
  a_hold_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    step && wait_r == '0 |=> wait_r[1:0] == 2'b11 &&
                             wait_r <= HOLD_W'(BLINK_FIRST_HOLD - 1))
    else $error("bad hold loaded on write");

  // Walk position and sub-pattern stay in range
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.grp <= GRP_W'(MAX_GROUPS) && st_r.sub != SUB_W'(SUB_COUNT) &&
    st_r.hold >= HOLD_W'(MIN_HOLD))
    else $error("walk state out of range");

endmodule

// File: sv/led_chaser_pattern_sequencer_unit.sv
// 16-channel light-pattern generator. Each input beat is one millisecond tick
// (in_tick_enable = 1) or a no-op (0); every beat returns exactly one output
// beat carrying the 16 pin levels after that tick (1 = HIGH) and the index of
// the sequence being played. Four sequences rotate forever: blink with holds
// 100..8 ms, forward snake and reverse snake with holds 20..8 ms, and a mixed
// snake/blink/reverse-snake sequence (blink holds 100..8 ms, snake holds 4 ms).
// cfg_wr_data sets how many 8-pin groups the forward snake walks (values above
// 2 act as 2, 0 skips it); write it only between beats, it applies from the
// next pin write. Throughput is one beat per clock unless out_ready stalls the
// result register; each beat passes the input register, the combinational tick
// logic and the result register. in_ready follows out_ready combinationally
// when both registers are full. Pins reset to all HIGH, sequence 0, group count 2.
module led_chaser_pattern_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_tick_enable,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lcps_pkg::LEVEL_W-1:0] out_pin_levels,
  output logic [lcps_pkg::SEQ_W-1:0]   out_sequence_now,
  input  logic                         cfg_wr_en,
  input  logic [lcps_pkg::CNT_W-1:0]   cfg_wr_data
);
  import lcps_pkg::*;

  // configuration
  logic [CNT_W-1:0]   expander_count_r;

  // input register
  logic               hold_valid_r;
  logic               hold_tick_r;

  // result register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_levels_r;
  logic [SEQ_W-1:0]   out_seq_r;

  logic               advance;
  logic               step;
  logic [LEVEL_W-1:0] eng_levels;
  logic [SEQ_W-1:0]   eng_seq;

  // Held beat moves on when the result slot is free or being drained
  assign advance  = hold_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !hold_valid_r || advance;
  assign step     = advance && hold_tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expander_count_r <= CNT_W'(MAX_GROUPS);
    end else if (cfg_wr_en) begin
      expander_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_tick_r <= in_tick_enable;
    end
  end

  lcps_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .expander_count (expander_count_r),
    .pin_levels_nxt (eng_levels),
    .sequence_nxt   (eng_seq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result carries the state after this beat's tick (or unchanged on a no-op)
  always_ff @(posedge clk) begin
    if (advance) begin
      out_levels_r <= eng_levels;
      out_seq_r    <= eng_seq;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pin_levels   = out_levels_r;
  assign out_sequence_now = out_seq_r;

endmodule
